@@ design/bezier_point_antialias_splat_macros.svh @@
// ----------------------------------------------------------------------------
// bezier point splat assertion macros
// shared concurrent assertion forms for the splat design
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_ANTIALIAS_SPLAT_MACROS_SVH
`define BEZIER_POINT_ANTIALIAS_SPLAT_MACROS_SVH

// property must hold at every edge outside reset
`define BPAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define BPAS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/bpas_pkg.sv @@
// ----------------------------------------------------------------------------
// bpas_pkg
// types and constants shared by the bezier point splat modules
// ----------------------------------------------------------------------------
package bpas_pkg;

    localparam int COORD_W       = 10;
    localparam int INTEN_W       = 8;
    localparam int T_W           = 17;
    localparam int T_BITS        = 16;
    localparam int NUM_PTS       = 4;
    localparam int NUM_NBR       = 9;
    localparam int CFG_REG_COUNT = 8;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL0_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL0_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL1_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL1_Y = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL2_X = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL2_Y = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL3_X = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL3_Y = 8'd7;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [INTEN_W-1:0] inten_t;

    typedef struct packed {
        logic [NUM_PTS-1:0][COORD_W-1:0] x;
        logic [NUM_PTS-1:0][COORD_W-1:0] y;
    } ctrl_pts_t;

    // nine candidate pixels of one t, in visit order
    typedef struct packed {
        logic [NUM_NBR-1:0]              mask;
        logic [NUM_NBR-1:0][COORD_W-1:0] x;
        logic [NUM_NBR-1:0][COORD_W-1:0] y;
        logic [NUM_NBR-1:0][INTEN_W-1:0] inten;
    } cand_t;

endpackage

@@ design/bpas_eval.sv @@
// ----------------------------------------------------------------------------
// bpas_eval
// six stage pipeline: three de casteljau levels, neighbour gaps, distance
// test and intensity for the nine pixels around the curve point
// ----------------------------------------------------------------------------
module bpas_eval
    import bpas_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int FRAC_BITS    = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [T_W-1:0]  t_param,
    input  ctrl_pts_t       ctrl,
    output logic            out_valid,
    input  logic            out_ready,
    output cand_t           cand
);

    localparam int VW    = COORD_W + FRAC_BITS;
    localparam int XW    = $clog2(FRAME_WIDTH);
    localparam int YW    = $clog2(FRAME_HEIGHT);
    localparam int CXW   = (XW > COORD_W) ? XW : COORD_W;
    localparam int CYW   = (YW > COORD_W) ? YW : COORD_W;
    localparam int GXW   = CXW + FRAC_BITS;
    localparam int GYW   = CYW + FRAC_BITS;
    localparam int DW    = ((GXW > GYW) ? GXW : GYW) + 1;
    localparam int RW    = FRAC_BITS + 2;
    localparam int NSTG  = 6;

    localparam logic [GXW-1:0] HALF_X = GXW'(1) << (FRAC_BITS - 1);
    localparam logic [GYW-1:0] HALF_Y = GYW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0]  TWO    = DW'(2) << FRAC_BITS;
    localparam logic [XW-1:0]  X_MAX  = XW'(FRAME_WIDTH - 1);
    localparam logic [YW-1:0]  Y_MAX  = YW'(FRAME_HEIGHT - 1);

    // a + round((b - a) * t), exact against the two-product form
    function automatic logic [VW-1:0] mix(
        input logic [VW-1:0]  a,
        input logic [VW-1:0]  b,
        input logic [T_W-1:0] t
    );
        logic signed [VW:0]    d;
        logic signed [VW+18:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, t});
        p = p + $signed((VW+19)'(32768));
        return a + VW'(p >>> T_BITS);
    endfunction

    logic                  en;
    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       vld_next;

    logic [T_W-1:0]        t_sat;
    logic [VW-1:0]         x0 [NUM_PTS];
    logic [VW-1:0]         y0 [NUM_PTS];

    logic [T_W-1:0]        t1_reg;
    logic [VW-1:0]         x1_reg [3];
    logic [VW-1:0]         y1_reg [3];
    logic [VW-1:0]         x1_next [3];
    logic [VW-1:0]         y1_next [3];

    logic [T_W-1:0]        t2_reg;
    logic [VW-1:0]         x2_reg [2];
    logic [VW-1:0]         y2_reg [2];
    logic [VW-1:0]         x2_next [2];
    logic [VW-1:0]         y2_next [2];

    logic [VW-1:0]         px3_reg;
    logic [VW-1:0]         py3_reg;
    logic [VW-1:0]         px3_next;
    logic [VW-1:0]         py3_next;

    logic [COORD_W-1:0]    ipx;
    logic [COORD_W-1:0]    ipy;
    logic [CXW-1:0]        ipx_c;
    logic [CYW-1:0]        ipy_c;
    logic [XW-1:0]         cx;
    logic [YW-1:0]         cy;
    logic [XW-1:0]         nx [3];
    logic [YW-1:0]         ny [3];
    logic [GXW-1:0]        pe_x;
    logic [GYW-1:0]        pe_y;
    logic [GXW-1:0]        me_x [3];
    logic [GYW-1:0]        me_y [3];
    logic [GXW-1:0]        gx4_next [3];
    logic [GYW-1:0]        gy4_next [3];
    logic [GXW-1:0]        gx4_reg [3];
    logic [GYW-1:0]        gy4_reg [3];
    logic [COORD_W-1:0]    nx4_next [3];
    logic [COORD_W-1:0]    ny4_next [3];
    logic [COORD_W-1:0]    nx4_reg [3];
    logic [COORD_W-1:0]    ny4_reg [3];

    logic [DW-1:0]         man_dist [NUM_NBR];
    logic [NUM_NBR-1:0]    mask5_next;
    logic [RW-1:0]         rem5_next [NUM_NBR];
    logic [NUM_NBR-1:0]    mask5_reg;
    logic [RW-1:0]         rem5_reg [NUM_NBR];
    logic [COORD_W-1:0]    nx5_reg [3];
    logic [COORD_W-1:0]    ny5_reg [3];

    logic [RW+7:0]         prod [NUM_NBR];
    cand_t                 cand_next;
    cand_t                 cand_reg;

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTG-1];
    assign cand      = cand_reg;
    assign vld_next  = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // level one of the interpolation
    always_comb
    begin
        t_sat = (t_param > T_ONE) ? T_ONE : t_param;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            x0[i] = {ctrl.x[i], {FRAC_BITS{1'b0}}};
            y0[i] = {ctrl.y[i], {FRAC_BITS{1'b0}}};
        end
        for (int i = 0; i < 3; i++)
        begin
            x1_next[i] = mix(x0[i], x0[i+1], t_sat);
            y1_next[i] = mix(y0[i], y0[i+1], t_sat);
        end
    end

    // level two
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            x2_next[i] = mix(x1_reg[i], x1_reg[i+1], t1_reg);
            y2_next[i] = mix(y1_reg[i], y1_reg[i+1], t1_reg);
        end
    end

    // level three gives the curve point
    assign px3_next = mix(x2_reg[0], x2_reg[1], t2_reg);
    assign py3_next = mix(y2_reg[0], y2_reg[1], t2_reg);

    // pixel, clamped neighbours and per-axis gaps
    always_comb
    begin
        ipx   = px3_reg[VW-1 -: COORD_W];
        ipy   = py3_reg[VW-1 -: COORD_W];
        ipx_c = CXW'(ipx);
        ipy_c = CYW'(ipy);
        cx    = (ipx_c > CXW'(X_MAX)) ? X_MAX : XW'(ipx_c);
        cy    = (ipy_c > CYW'(Y_MAX)) ? Y_MAX : YW'(ipy_c);
        nx[0] = cx;
        nx[1] = (cx == '0) ? cx : cx - 1'b1;
        nx[2] = (cx == X_MAX) ? cx : cx + 1'b1;
        ny[0] = cy;
        ny[1] = (cy == '0) ? cy : cy - 1'b1;
        ny[2] = (cy == Y_MAX) ? cy : cy + 1'b1;
        pe_x  = GXW'(px3_reg);
        pe_y  = GYW'(py3_reg);
        for (int j = 0; j < 3; j++)
        begin
            me_x[j]     = (GXW'(nx[j]) << FRAC_BITS) + HALF_X;
            me_y[j]     = (GYW'(ny[j]) << FRAC_BITS) + HALF_Y;
            gx4_next[j] = (pe_x > me_x[j]) ? pe_x - me_x[j] : me_x[j] - pe_x;
            gy4_next[j] = (pe_y > me_y[j]) ? pe_y - me_y[j] : me_y[j] - pe_y;
            nx4_next[j] = COORD_W'(nx[j]);
            ny4_next[j] = COORD_W'(ny[j]);
        end
    end

    // manhattan distance and coverage test, column outer, row inner
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                man_dist[j*3+k]   = DW'(gx4_reg[j]) + DW'(gy4_reg[k]);
                mask5_next[j*3+k] = man_dist[j*3+k] < TWO;
                rem5_next[j*3+k]  = RW'(TWO - man_dist[j*3+k]);
            end
        end
    end

    // intensity = rem * 255 >> (frac + 1)
    always_comb
    begin
        cand_next.mask = mask5_reg;
        for (int n = 0; n < NUM_NBR; n++)
        begin
            prod[n]            = {rem5_reg[n], 8'd0} - {8'd0, rem5_reg[n]};
            cand_next.inten[n] = prod[n][FRAC_BITS+8 : FRAC_BITS+1];
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cand_next.x[j*3+k] = nx5_reg[j];
                cand_next.y[j*3+k] = ny5_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= t_sat;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            t2_reg    <= t1_reg;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            px3_reg   <= px3_next;
            py3_reg   <= py3_next;
            gx4_reg   <= gx4_next;
            gy4_reg   <= gy4_next;
            nx4_reg   <= nx4_next;
            ny4_reg   <= ny4_next;
            mask5_reg <= mask5_next;
            rem5_reg  <= rem5_next;
            nx5_reg   <= nx4_reg;
            ny5_reg   <= ny4_reg;
            cand_reg  <= cand_next;
        end
    end

endmodule

@@ design/bpas_emit.sv @@
// ----------------------------------------------------------------------------
// bpas_emit
// holds one candidate set; one covered pixel per cycle while m_tready is high
// ----------------------------------------------------------------------------
`include "bezier_point_antialias_splat_macros.svh"

module bpas_emit
    import bpas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cand_t       cand,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    logic [NUM_NBR-1:0] pend_reg;
    logic [NUM_NBR-1:0] pend_next;
    cand_t              hold_reg;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    coord_t             pixel_x_reg;
    coord_t             pixel_y_reg;
    inten_t             inten_reg;
    logic               last_reg;

    logic               out_free;
    logic               take;
    logic               load;
    logic [NUM_NBR-1:0] low;
    logic [NUM_NBR-1:0] rest;
    logic [3:0]         sel;

    assign out_free = !m_tvalid_reg || m_tready;
    assign take     = hold_valid_reg && out_free;
    assign low      = pend_reg & (~pend_reg + NUM_NBR'(1));
    assign rest     = pend_reg & ~low;
    assign in_ready = !hold_valid_reg || (take && (rest == '0));
    assign load     = in_valid && in_ready;

    // lowest pending candidate goes first
    always_comb
    begin
        sel = '0;
        for (int n = NUM_NBR - 1; n >= 0; n--)
        begin
            if (pend_reg[n])
            begin
                sel = 4'(n);
            end
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        pend_next       = pend_reg;
        m_tvalid_next   = m_tvalid_reg;
        if (out_free)
        begin
            m_tvalid_next = take;
        end
        if (take)
        begin
            pend_next       = rest;
            hold_valid_next = (rest != '0);
        end
        if (load)
        begin
            pend_next       = cand.mask;
            hold_valid_next = (cand.mask != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pend_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pend_reg       <= pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= cand;
        end
        if (take)
        begin
            pixel_x_reg <= hold_reg.x[sel];
            pixel_y_reg <= hold_reg.y[sel];
            inten_reg   <= hold_reg.inten[sel];
            last_reg    <= (rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, inten_reg, pixel_y_reg, pixel_x_reg};
    assign m_tlast  = last_reg;

    `BPAS_ASSERT(a_hold_has_work, clk, rst_n, hold_valid_reg |-> (pend_reg != '0), "held set without pending pixel")
    `BPAS_ASSERT(a_load_covered, clk, rst_n, (load && (cand.mask != '0)) |=> hold_valid_reg, "covered set not held")
    `BPAS_ASSERT(a_out_from_hold, clk, rst_n, $rose(m_tvalid_reg) |-> $past(hold_valid_reg), "item sent without held set")

endmodule

@@ design/bezier_point_antialias_splat.sv @@
// ----------------------------------------------------------------------------
// bezier_point_antialias_splat
// cubic bezier point evaluation with a nine pixel anti-aliased footprint
// ----------------------------------------------------------------------------
// usage:
//   the cfg channel writes the four control points (index 0..7: x0 y0 x1 y1
//   x2 y2 x3 y3, low 10 bits of cfg_data); it is always ready, and it must be
//   written while the block is idle, which the block itself does not enforce
//   the s_ channel takes one curve parameter t (s_tdata[16:0], t/65536)
//   the m_ channel gives, per t, each covered pixel of the 3x3 footprint in
//   column-outer, row-inner order, tlast on the final one; a t that covers
//   no pixel gives no item
// path: the first item of a t passes through six pipeline stages, one hold
//   stage and one output register after the t is accepted
// throughput: the single output register sends one pixel a cycle while m_tready
//   is high; a new t's set is loaded as the last pixel of the held one is sent
// reset clears all control points to zero and empties the pipeline
// when m_tready is low the output holds, the pipeline fills and s_tready
// falls; nothing is lost or repeated
// ----------------------------------------------------------------------------
module bezier_point_antialias_splat
    import bpas_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // t_param[16:0], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // pixel_x[9:0], pixel_y[19:10],
                                             // intensity[27:20], zero pad
    output logic                  m_tlast    // last_of_run
);

    coord_t    ctrl_reg [CFG_REG_COUNT];
    ctrl_pts_t ctrl;
    logic      eval_valid;
    logic      eval_ready;
    cand_t     eval_cand;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REG_COUNT; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_REG_COUNT)))
        begin
            ctrl_reg[3'(cfg_index)] <= cfg_data[COORD_W-1:0];
        end
    end

    always_comb
    begin
        ctrl.x[0] = ctrl_reg[CFG_CTRL0_X[2:0]];
        ctrl.y[0] = ctrl_reg[CFG_CTRL0_Y[2:0]];
        ctrl.x[1] = ctrl_reg[CFG_CTRL1_X[2:0]];
        ctrl.y[1] = ctrl_reg[CFG_CTRL1_Y[2:0]];
        ctrl.x[2] = ctrl_reg[CFG_CTRL2_X[2:0]];
        ctrl.y[2] = ctrl_reg[CFG_CTRL2_Y[2:0]];
        ctrl.x[3] = ctrl_reg[CFG_CTRL3_X[2:0]];
        ctrl.y[3] = ctrl_reg[CFG_CTRL3_Y[2:0]];
    end

    bpas_eval #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .t_param   (s_tdata[T_W-1:0]),
        .ctrl      (ctrl),
        .out_valid (eval_valid),
        .out_ready (eval_ready),
        .cand      (eval_cand)
    );

    bpas_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (eval_valid),
        .in_ready (eval_ready),
        .cand     (eval_cand),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// bezier point splat testbench
// programs control points, streams curve parameters and checks every emitted
// pixel, intensity and run marker against a de casteljau predictor
// ----------------------------------------------------------------------------
module testbench
    import bpas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W        = 1024;
    localparam int FRAME_H        = 1024;
    localparam int FRAC           = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_IDX_W'(CFG_REG_COUNT);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP          = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_BIT     = 8'h80;

    typedef struct {
        coord_t x;
        coord_t y;
        inten_t inten;
        logic   last;
    } pixel_hit_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  m_tlast;

    coord_t     curve_pt [CFG_REG_COUNT];
    pixel_hit_t pending_pixels [$];
    int         err_cnt;
    int         quiet_cycles;
    int         send_idle_pct;
    int         recv_stall_pct;

    bezier_point_antialias_splat #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H),
        .FRAC_BITS    (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] lerp_fx(logic [63:0] a, logic [63:0] b, logic [63:0] t);
        return (a * (64'(T_ONE) - t) + b * t + (64'(T_ONE) >> 1)) >> T_BITS;
    endfunction

    function automatic int clamp_px(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [63:0] gap_fx(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // expected pixels of one t, in column-outer, row-inner order
    task automatic predict_splat(input logic [T_W-1:0] t_raw);
        logic [63:0] tq;
        logic [63:0] xs [NUM_PTS];
        logic [63:0] ys [NUM_PTS];
        logic [63:0] mx, my, gap_sum, two, half;
        int          nbr_off [3];
        int          cx, cy, nx, ny, first;
        pixel_hit_t  hit;
        nbr_off = '{0, -1, 1};
        first = pending_pixels.size();
        tq = (t_raw > T_ONE) ? 64'(T_ONE) : 64'(t_raw);
        for (int i = 0; i < NUM_PTS; i++)
        begin
            xs[i] = 64'(curve_pt[2 * i]) << FRAC;
            ys[i] = 64'(curve_pt[2 * i + 1]) << FRAC;
        end
        for (int lvl = NUM_PTS - 1; lvl >= 1; lvl--)
        begin
            for (int i = 0; i < lvl; i++)
            begin
                xs[i] = lerp_fx(xs[i], xs[i + 1], tq);
                ys[i] = lerp_fx(ys[i], ys[i + 1], tq);
            end
        end
        cx = clamp_px(int'(xs[0] >> FRAC), FRAME_W - 1);
        cy = clamp_px(int'(ys[0] >> FRAC), FRAME_H - 1);
        two = 64'(2) << FRAC;
        half = 64'(1) << (FRAC - 1);
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nx = clamp_px(cx + nbr_off[j], FRAME_W - 1);
                ny = clamp_px(cy + nbr_off[k], FRAME_H - 1);
                mx = (64'(nx) << FRAC) + half;
                my = (64'(ny) << FRAC) + half;
                gap_sum = gap_fx(xs[0], mx) + gap_fx(ys[0], my);
                if (gap_sum < two)
                begin
                    hit.x = coord_t'(nx);
                    hit.y = coord_t'(ny);
                    hit.inten = inten_t'(((two - gap_sum) * 255) >> (FRAC + 1));
                    hit.last = 1'b0;
                    pending_pixels.push_back(hit);
                end
            end
        end
        if (pending_pixels.size() > first)
            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // output side: compare each item, then pick next ready
    always @(posedge clk)
    begin
        pixel_hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected item: pixel_x %0d pixel_y %0d intensity %0d",
                       m_tdata[9:0], m_tdata[19:10], m_tdata[27:20]);
                err_cnt++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.x, m_tdata[9:0]);
                check_field("pixel_y", want.y, m_tdata[19:10]);
                check_field("intensity", want.inten, m_tdata[27:20]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // leaves cfg_valid high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_REG_COUNT)
            curve_pt[idx[2:0]] = coord_t'(data);
    endtask

    task automatic program_curve(input logic [CFG_DATA_W-1:0] x0, input logic [CFG_DATA_W-1:0] y0,
                                 input logic [CFG_DATA_W-1:0] x1, input logic [CFG_DATA_W-1:0] y1,
                                 input logic [CFG_DATA_W-1:0] x2, input logic [CFG_DATA_W-1:0] y2,
                                 input logic [CFG_DATA_W-1:0] x3, input logic [CFG_DATA_W-1:0] y3,
                                 input bit stray);
        write_reg(CFG_CTRL0_X, x0);
        write_reg(CFG_CTRL0_Y, y0);
        write_reg(CFG_CTRL1_X, x1);
        write_reg(CFG_CTRL1_Y, y1);
        write_reg(CFG_CTRL2_X, x2);
        write_reg(CFG_CTRL2_Y, y2);
        write_reg(CFG_CTRL3_X, x3);
        write_reg(CFG_CTRL3_Y, y3);
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_IDX_FIRST_UNUSED)),
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // leaves s_tvalid high so back-to-back items need no toggle
    task automatic send_t(input logic [T_W-1:0] t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 24'(t);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_splat(t);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coord_word();
        logic [COORD_W-1:0] c;
        case ($urandom_range(9))
            0:       c = '0;
            1:       c = '1;
            2:       c = COORD_W'($urandom_range(3));
            3:       c = COORD_W'($urandom_range(1023, 1020));
            default: c = COORD_W'($urandom);
        endcase
        return {(CFG_DATA_W - COORD_W)'($urandom), c};
    endfunction

    function automatic logic [T_W-1:0] pick_t();
        case ($urandom_range(19))
            0:       return '0;
            1:       return T_ONE;
            2, 3:    return T_W'($urandom_range(131071, 65537));
            default: return T_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic test_degenerate_curves();
        program_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_t(T_W'(0));
        send_t(T_ONE);
        send_t('1);
        wait_drain();
        program_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_t(T_W'(0));
        send_t(T_W'(32768));
        wait_drain();
    endtask

    task automatic test_frame_corners();
        program_curve(16'd0, 16'd0, 16'd1023, 16'd0,
                      16'd0, 16'd1023, 16'd1023, 16'd1023, 1'b0);
        send_t(T_W'(0));
        send_t(T_W'(1));
        send_t(T_W'(16384));
        send_t(T_W'(32768));
        send_t(T_W'(49152));
        send_t(T_W'(65535));
        send_t(T_ONE);
        send_t(T_W'(65537));
        send_t(T_W'(98304));
        wait_drain();
    endtask

    task automatic test_register_map();
        write_reg(CFG_CTRL0_X, 16'hFC05);
        write_reg(CFG_IDX_FIRST_UNUSED, 16'hFFFF);
        write_reg(CFG_IDX_HIGH_BIT, 16'h0155);
        write_reg(CFG_IDX_TOP, 16'h02AA);
        write_reg(CFG_CTRL3_Y, 16'h8200);
        cfg_valid <= 1'b0;
        send_t(T_W'(0));
        send_t(T_W'(21845));
        send_t(T_W'(43690));
        wait_drain();
    endtask

    task automatic test_random_curves();
        int stall_mode [4][2];
        stall_mode = '{'{0, 0}, '{84, 0}, '{0, 84}, '{23, 23}};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = stall_mode[ph][0];
            recv_stall_pct = stall_mode[ph][1];
            for (int cv = 0; cv < 2; cv++)
            begin
                program_curve(pick_coord_word(), pick_coord_word(), pick_coord_word(),
                              pick_coord_word(), pick_coord_word(), pick_coord_word(),
                              pick_coord_word(), pick_coord_word(), $urandom_range(1) == 1);
                for (int n = 0; n < 12; n++)
                    send_t(pick_t());
                wait_drain();
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        err_cnt        = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < CFG_REG_COUNT; i++)
            curve_pt[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_curves();
        test_frame_corners();
        test_register_map();
        test_random_curves();

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
